// ===== sv/bit_field_packer_defines.svh =====
// ----------------------------------------------------------------------------
// Bit field packer assertion macros
// Clocked assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BIT_FIELD_PACKER_DEFINES_SVH
`define BIT_FIELD_PACKER_DEFINES_SVH

`ifndef SYNTH

// property that must hold at every clock edge out of reset
`define BFP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bit_field_packer assertion failed");

// consequent that must hold in the cycle after the antecedent
`define BFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bit_field_packer assertion failed");

`else

`define BFP_ASSERT(label, clk, rst_n, prop)
`define BFP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/bfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Bit field packer package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package bfp_pkg;

    localparam int MAX_WIDTH_DEF = 32;
    localparam int CFG_W         = 6;
    localparam int CFG_IDX_W     = 1;
    localparam int VALUE_W       = 32;
    localparam int WORD_W        = 32;
    localparam int OQ_DEPTH      = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH = 1'b1;

    localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = 6'd7;
    localparam logic [CFG_W-1:0] DEST_WIDTH_RST = 6'd8;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last_res;
    } out_item_t;

    typedef struct packed {
        logic      push0;
        logic      push1;
        out_item_t item0;
        out_item_t item1;
    } push_t;

endpackage

`default_nettype wire

// ===== sv/bfp_pack_core.sv =====
// ----------------------------------------------------------------------------
// Bit field packer core
// Width registers, bit accumulator and the combinational append/emit logic.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bit_field_packer_defines.svh"

module bfp_pack_core #(
    parameter int MAX_WIDTH = bfp_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [bfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bfp_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          item_valid,
    input  wire bfp_pkg::in_item_t             item,
    output bfp_pkg::push_t                     push
);

    localparam int CW   = bfp_pkg::CFG_W;
    localparam int WW   = bfp_pkg::WORD_W;
    localparam int M    = MAX_WIDTH;
    localparam int AW   = 2 * M;
    localparam int HW   = $clog2(M);
    localparam int DW_W = $clog2(M + 1);
    localparam int SUMW = $clog2(2 * M);

    logic [CW-1:0]   src_width_reg;
    logic [CW-1:0]   dest_width_reg;
    logic [M-1:0]    acc_reg;
    logic [M-1:0]    acc_next;
    logic [HW-1:0]   held_reg;
    logic [HW-1:0]   held_next;

    logic [DW_W-1:0] dw;
    logic [DW_W-1:0] sw;
    logic [AW-1:0]   src_mask;
    logic [AW-1:0]   dest_mask;
    logic [M-1:0]    held_mask;
    logic [M-1:0]    rem_mask;
    logic [M-1:0]    v_m;
    logic [AW-1:0]   combined;
    logic [SUMW-1:0] sum;
    logic            full;
    logic [AW-1:0]   rem_acc;
    logic [HW-1:0]   rem_held;
    logic [M-1:0]    full_bits;
    logic [M-1:0]    flush_bits;
    logic            flush;

    always_comb
    begin
        if (dest_width_reg == '0)
        begin
            dw = DW_W'(1);
        end
        else if (dest_width_reg > CW'(M))
        begin
            dw = DW_W'(M);
        end
        else
        begin
            dw = dest_width_reg[DW_W-1:0];
        end

        if (src_width_reg > CW'(dw))
        begin
            sw = dw;
        end
        else
        begin
            sw = src_width_reg[DW_W-1:0];
        end
    end

    assign src_mask  = (AW'(1) << sw) - AW'(1);
    assign dest_mask = (AW'(1) << dw) - AW'(1);
    assign held_mask = (M'(1) << held_reg) - M'(1);
    assign v_m       = item.value[M-1:0] & src_mask[M-1:0];
    assign combined  = {{M{1'b0}}, acc_reg & held_mask} | ({{M{1'b0}}, v_m} << held_reg);
    assign sum       = SUMW'(held_reg) + SUMW'(sw);
    assign full      = sum >= SUMW'(dw);
    assign rem_acc   = full ? (combined >> dw) : combined;
    assign rem_held  = full ? HW'(sum - SUMW'(dw)) : HW'(sum);
    assign rem_mask  = (M'(1) << rem_held) - M'(1);
    assign full_bits = combined[M-1:0] & dest_mask[M-1:0];
    assign flush_bits = rem_acc[M-1:0] & rem_mask;
    assign flush     = item.last && (rem_held != '0);

    always_comb
    begin
        push.push0          = item_valid && (full || flush);
        push.push1          = item_valid && full && flush;
        push.item1.word     = WW'(flush_bits);
        push.item1.last_res = 1'b1;
        if (full)
        begin
            push.item0.word     = WW'(full_bits);
            push.item0.last_res = item.last && (rem_held == '0);
        end
        else
        begin
            push.item0.word     = WW'(flush_bits);
            push.item0.last_res = 1'b1;
        end
    end

    always_comb
    begin
        acc_next  = acc_reg;
        held_next = held_reg;
        if (cfg_we)
        begin
            acc_next  = '0;
            held_next = '0;
        end
        else if (item_valid)
        begin
            if (item.last)
            begin
                acc_next  = '0;
                held_next = '0;
            end
            else
            begin
                acc_next  = rem_acc[M-1:0];
                held_next = rem_held;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= bfp_pkg::SRC_WIDTH_RST;
            dest_width_reg <= bfp_pkg::DEST_WIDTH_RST;
            acc_reg        <= '0;
            held_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bfp_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                    bfp_pkg::REG_DEST_WIDTH: dest_width_reg <= cfg_data;
                    default: ;
                endcase
            end
            acc_reg  <= acc_next;
            held_reg <= held_next;
        end
    end

    `BFP_ASSERT(a_held_below_width, clk, rst_n, DW_W'(held_reg) < dw)
    `BFP_ASSERT_NEXT(a_last_empties, clk, rst_n, item_valid && item.last && !cfg_we, held_reg == '0)

endmodule

`default_nettype wire

// ===== sv/bfp_out_queue.sv =====
// ----------------------------------------------------------------------------
// Bit field packer result queue
// Register FIFO: up to two results in per cycle, one out per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bit_field_packer_defines.svh"

module bfp_out_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bfp_pkg::push_t      push,
    output logic                     room,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output bfp_pkg::out_item_t       out_data
);

    localparam int DEPTH = bfp_pkg::OQ_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bfp_pkg::out_item_t entries [DEPTH];

    logic [PW-1:0]    wptr_reg;
    logic [PW-1:0]    wptr_next;
    logic [PW-1:0]    rptr_reg;
    logic [PW-1:0]    rptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    assign out_valid = count_reg != '0;
    assign out_data  = entries[rptr_reg];
    assign pop       = out_valid && !out_stall;
    assign room      = count_reg <= CNT_W'(DEPTH - 2);

    always_comb
    begin
        wptr_next  = wptr_reg + PW'(push.push0) + PW'(push.push1);
        rptr_next  = rptr_reg + PW'(pop);
        count_next = count_reg + CNT_W'(push.push0) + CNT_W'(push.push1) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            entries[wptr_reg] <= push.item0;
        end
        if (push.push1)
        begin
            entries[wptr_reg + PW'(1)] <= push.item1;
        end
    end

    `BFP_ASSERT(a_count_in_range, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `BFP_ASSERT(a_push_has_room, clk, rst_n, !push.push0 || room)
    `BFP_ASSERT(a_push_order, clk, rst_n, !push.push1 || push.push0)
    `BFP_ASSERT_NEXT(a_drain_last, clk, rst_n, pop && !push.push0 && count_reg == CNT_W'(1),
        !out_valid)

endmodule

`default_nettype wire

// ===== sv/bit_field_packer.sv =====
// ----------------------------------------------------------------------------
// Bit field packer
// LSB-first packing of src_width-bit values into dest_width-bit words.
//
//   channel  signals                      direction  transaction
//   in       in_valid in_stall in_data    sink       one source value
//   out      out_valid out_stall out_data source     one packed word
//   cfg      cfg_we cfg_index cfg_data    sink       one width register write
//
// One input transaction per cycle while in_stall is low; a packed word goes
// from the input register through the append/emit logic into the result
// queue. The four-entry result queue sets the stall: in_stall rises when the
// input register holds a value and the queue has fewer than two free slots.
// rst_n clears all control state and loads widths 7 and 8; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_field_packer #(
    parameter int MAX_WIDTH = bfp_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [bfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bfp_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire bfp_pkg::in_item_t             in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output bfp_pkg::out_item_t                 out_data
);

    logic              in_valid_reg;
    logic              in_valid_next;
    bfp_pkg::in_item_t in_item_reg;
    logic              room;
    logic              advance;
    bfp_pkg::push_t    push;

    assign advance  = in_valid_reg && room;
    assign in_stall = in_valid_reg && !room;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (!in_stall)
        begin
            in_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            in_item_reg <= in_data;
        end
    end

    bfp_pack_core #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (advance),
        .item       (in_item_reg),
        .push       (push)
    );

    bfp_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Bit field packer testbench
// Drives source values with random gaps and a directed table. A built-in
// packing predictor computes the expected words, save those a directed row
// gives. Every packed word taken from the output is checked in order against
// them. Width registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASES      = 25;
    localparam int PHASE_ITEMS = 50;
    localparam int HOLD_CYCLES = 300;
    localparam int CW          = bfp_pkg::CFG_W;
    localparam int IW          = bfp_pkg::CFG_IDX_W;

    typedef struct packed {
        logic [1:0]         n;
        bfp_pkg::out_item_t w0;
        bfp_pkg::out_item_t w1;
    } pack_result_t;

    typedef struct packed {
        logic               is_cfg;
        logic [IW-1:0]      reg_idx;
        logic [CW-1:0]      reg_val;
        bfp_pkg::in_item_t  item;
        logic               typed;
        logic [1:0]         n_typed;
        bfp_pkg::out_item_t t0;
        bfp_pkg::out_item_t t1;
    } dir_row_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [IW-1:0]      cfg_index = '0;
    logic [CW-1:0]      cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    bfp_pkg::in_item_t  in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b1;
    bfp_pkg::out_item_t out_data;

    logic [CW-1:0] src_cfg  = bfp_pkg::SRC_WIDTH_RST;
    logic [CW-1:0] dest_cfg = bfp_pkg::DEST_WIDTH_RST;
    logic [63:0]   pack_acc  = '0;
    int unsigned   pack_held = 0;

    bfp_pkg::out_item_t expected_words[$];
    int unsigned n_errors   = 0;
    int unsigned idle_count = 0;
    bit          send_busy  = 1'b0;
    bit          sending    = 1'b0;
    bit          hold_phase = 1'b0;

    bit_field_packer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [63:0] low_bits(input int unsigned n);
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic pack_result_t pack_step(input bfp_pkg::in_item_t item);
        pack_result_t       r;
        int unsigned        dw;
        int unsigned        sw;
        int unsigned        held;
        logic [63:0]        v;
        logic [63:0]        m;
        bfp_pkg::out_item_t flush;
        r = '0;
        if (dest_cfg == 0)
            dw = 1;
        else if (dest_cfg > bfp_pkg::MAX_WIDTH_DEF)
            dw = bfp_pkg::MAX_WIDTH_DEF;
        else
            dw = int'(dest_cfg);
        sw = (src_cfg > dw) ? dw : int'(src_cfg);
        v = {32'b0, item.value} & low_bits(sw);
        held = pack_held;
        pack_acc = (pack_acc & low_bits(held)) | (v << held);
        held += sw;
        if (held >= dw)
        begin
            m = pack_acc & low_bits(dw);
            r.w0.word = m[31:0];
            r.w0.last_res = 1'b0;
            pack_acc = pack_acc >> dw;
            held -= dw;
            r.n = 2'd1;
        end
        if (item.last)
        begin
            if (held > 0)
            begin
                m = pack_acc & low_bits(held);
                flush.word = m[31:0];
                flush.last_res = 1'b1;
                if (r.n == 0)
                    r.w0 = flush;
                else
                    r.w1 = flush;
                r.n = r.n + 2'd1;
            end
            else if (r.n > 0)
            begin
                r.w0.last_res = 1'b1;
            end
            pack_acc = '0;
            held = 0;
        end
        pack_held = held;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [IW-1:0] idx,
                                         input logic [CW-1:0] val);
        dir_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic dir_row_t data_row(input logic [31:0] value, input logic last,
                                          input logic typed, input logic [1:0] n,
                                          input bfp_pkg::out_item_t t0,
                                          input bfp_pkg::out_item_t t1);
        dir_row_t r;
        r = '0;
        r.item.value = value;
        r.item.last = last;
        r.typed = typed;
        r.n_typed = n;
        r.t0 = t0;
        r.t1 = t1;
        return r;
    endfunction

    task automatic send_item(input bfp_pkg::in_item_t item, input logic typed,
                             input logic [1:0] n_typed,
                             input bfp_pkg::out_item_t t0, input bfp_pkg::out_item_t t1);
        pack_result_t r;
        int unsigned  gap;
        gap = send_busy ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        r = pack_step(item);
        if (typed)
        begin
            r.n = n_typed;
            r.w0 = t0;
            r.w1 = t1;
        end
        if (r.n > 0)
            expected_words.push_back(r.w0);
        if (r.n > 1)
            expected_words.push_back(r.w1);
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input logic [CW-1:0] val);
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == bfp_pkg::REG_SRC_WIDTH)
            src_cfg = val;
        else
            dest_cfg = val;
        pack_acc = '0;
        pack_held = 0;
    endtask

    // check each accepted word against the oldest expected word
    always @(posedge clk)
    begin
        bfp_pkg::out_item_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected word %h last_res %b", out_data.word, out_data.last_res);
                n_errors++;
            end
            else
            begin
                e = expected_words.pop_front();
                if (out_data.word !== e.word)
                begin
                    $error("word: expected %h, got %h", e.word, out_data.word);
                    n_errors++;
                end
                if (out_data.last_res !== e.last_res)
                begin
                    $error("last_res: expected %b, got %b", e.last_res, out_data.last_res);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
            if (idle_count >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin : receiver
        int unsigned gap;
        int unsigned n_recv;
        bit          busy;
        bit          held_off;
        n_recv = 0;
        busy = 1'b0;
        held_off = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (n_recv % 50 == 0)
                busy = ($urandom_range(0, 3) == 0);
            gap = busy ? 0 : $urandom_range(0, 11);
            if (!held_off && sending && hold_phase)
            begin
                gap = HOLD_CYCLES;
                held_off = 1'b1;
            end
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            n_recv++;
        end
    end

    initial
    begin : stimulus
        dir_row_t          rows[$];
        bfp_pkg::in_item_t item;
        logic [CW-1:0]     src_sel;
        logic [CW-1:0]     dest_sel;
        int unsigned       eff;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back(data_row(32'h0000_007F, 1'b1, 1'b1, 2'd1, {32'h0000_007F, 1'b1}, '0));
        rows.push_back(data_row(32'hFFFF_FFFF, 1'b0, 1'b1, 2'd0, '0, '0));
        rows.push_back(data_row(32'hFFFF_FFFF, 1'b1, 1'b1, 2'd2,
                                {32'h0000_00FF, 1'b0}, {32'h0000_003F, 1'b1}));
        rows.push_back(data_row(32'h55, 1'b0, 1'b0, 2'd0, '0, '0));
        rows.push_back(data_row(32'h2A, 1'b0, 1'b0, 2'd0, '0, '0));
        rows.push_back(data_row(32'h7F, 1'b0, 1'b0, 2'd0, '0, '0));
        rows.push_back(data_row(32'h00, 1'b0, 1'b0, 2'd0, '0, '0));
        rows.push_back(data_row(32'h41, 1'b0, 1'b0, 2'd0, '0, '0));
        rows.push_back(data_row(32'h3E, 1'b0, 1'b0, 2'd0, '0, '0));
        rows.push_back(data_row(32'h1C, 1'b0, 1'b0, 2'd0, '0, '0));
        rows.push_back(data_row(32'h63, 1'b1, 1'b0, 2'd0, '0, '0));
        rows.push_back(cfg_row(bfp_pkg::REG_DEST_WIDTH, 6'd32));
        rows.push_back(cfg_row(bfp_pkg::REG_SRC_WIDTH, 6'd32));
        rows.push_back(data_row(32'hFFFF_FFFF, 1'b1, 1'b1, 2'd1, {32'hFFFF_FFFF, 1'b1}, '0));
        rows.push_back(data_row(32'h0000_0000, 1'b1, 1'b1, 2'd1, {32'h0000_0000, 1'b1}, '0));
        rows.push_back(cfg_row(bfp_pkg::REG_SRC_WIDTH, 6'd63));
        rows.push_back(data_row(32'hDEAD_BEEF, 1'b0, 1'b1, 2'd1, {32'hDEAD_BEEF, 1'b0}, '0));
        rows.push_back(cfg_row(bfp_pkg::REG_DEST_WIDTH, 6'd0));
        rows.push_back(cfg_row(bfp_pkg::REG_SRC_WIDTH, 6'd0));
        rows.push_back(data_row(32'hFFFF_FFFF, 1'b1, 1'b1, 2'd0, '0, '0));
        rows.push_back(cfg_row(bfp_pkg::REG_SRC_WIDTH, 6'd1));
        rows.push_back(data_row(32'hFFFF_FFFF, 1'b1, 1'b1, 2'd1, {32'h0000_0001, 1'b1}, '0));
        rows.push_back(cfg_row(bfp_pkg::REG_DEST_WIDTH, 6'd63));
        rows.push_back(cfg_row(bfp_pkg::REG_SRC_WIDTH, 6'd5));
        rows.push_back(data_row(32'h0000_001F, 1'b0, 1'b1, 2'd0, '0, '0));
        rows.push_back(data_row(32'h0000_0000, 1'b1, 1'b1, 2'd1, {32'h0000_001F, 1'b1}, '0));
        rows.push_back(cfg_row(bfp_pkg::REG_DEST_WIDTH, 6'd3));
        rows.push_back(cfg_row(bfp_pkg::REG_SRC_WIDTH, 6'd2));
        rows.push_back(data_row(32'h3, 1'b0, 1'b0, 2'd0, '0, '0));
        rows.push_back(data_row(32'h2, 1'b0, 1'b0, 2'd0, '0, '0));
        rows.push_back(data_row(32'h1, 1'b1, 1'b0, 2'd0, '0, '0));

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            else
                send_item(rows[i].item, rows[i].typed, rows[i].n_typed,
                          rows[i].t0, rows[i].t1);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            sending = 1'b0;
            case ($urandom_range(0, 7))
                0:       dest_sel = 6'd0;
                1:       dest_sel = 6'd63;
                2:       dest_sel = 6'd32;
                3:       dest_sel = 6'd1;
                default: dest_sel = CW'($urandom_range(1, 32));
            endcase
            eff = (dest_sel == 0) ? 1 : (dest_sel > 32) ? 32 : int'(dest_sel);
            case ($urandom_range(0, 9))
                0:       src_sel = 6'd0;
                1:       src_sel = 6'd63;
                2:       src_sel = CW'(eff);
                3:       src_sel = CW'(eff + 1);
                default: src_sel = CW'($urandom_range(1, eff));
            endcase
            // one word per item with no sender gaps while the receiver holds off
            hold_phase = (ph == PHASES / 2);
            if (hold_phase)
            begin
                dest_sel = 6'd8;
                src_sel = 6'd8;
            end
            if ($urandom_range(0, 1))
            begin
                write_reg(bfp_pkg::REG_DEST_WIDTH, dest_sel);
                write_reg(bfp_pkg::REG_SRC_WIDTH, src_sel);
            end
            else
            begin
                write_reg(bfp_pkg::REG_SRC_WIDTH, src_sel);
                write_reg(bfp_pkg::REG_DEST_WIDTH, dest_sel);
            end
            send_busy = hold_phase || ($urandom_range(0, 3) == 0);
            sending = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                case ($urandom_range(0, 7))
                    0:       item.value = '0;
                    1:       item.value = '1;
                    default: item.value = $urandom;
                endcase
                item.last = ($urandom_range(0, 5) == 0);
                send_item(item, 1'b0, 2'd0, '0, '0);
            end
        end

        sending = 1'b0;
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
